// File: hw/rtl/llca_pkg.sv
// Shared widths and reset constants for the least-loaded core assigner.
package llca_pkg;

    localparam int WEIGHT_W      = 32;
    localparam int LOAD_W        = 48;
    localparam int ACTIVE_W      = 7;
    localparam int CORE_W        = 6;
    localparam int MAX_CORES_DEF = 64;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 7'd64;

endpackage

// File: hw/rtl/least_loaded_core_assigner_core.sv
// Least-loaded core assigner: greedy list scheduler over a memory of per-core loads.
//
// Use: each job arrives on the input channel (in_valid/in_ready) with its weight
// and a last_in_batch mark. The block scans the loads of the active cores, picks
// the smallest (lowest index on a tie), adds the weight to that load with
// saturation at 2^48-1, and returns the chosen core on the output channel
// (out_valid/out_ready). After a job marked last, all loads read as zero again.
// The active core count is written through cfg_valid/cfg_ready/cfg_data; a zero
// counts as one core and a value above MAX_CORES counts as MAX_CORES.
// Flow: a job is taken only in the idle state. The scan reads the loads of the
// N effective active cores in order through the single read port of the load
// memory, which delivers one load per cycle to the compare stage; the result is
// registered in the update state. The next job is taken after the write back.
// Reset clears the valid bit of every load entry at once, so all loads read as
// zero, and sets the active core count to 64; no clearing pass is needed.
// A stalled receiver holds the result register; the block still takes the next
// job and scans, then waits before the write back until the result is taken.
module least_loaded_core_assigner_core #(
    parameter int MAX_CORES = llca_pkg::MAX_CORES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [llca_pkg::WEIGHT_W-1:0] job_weight,
    input  logic                          last_in_batch,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [llca_pkg::CORE_W-1:0]   assigned_core,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [llca_pkg::ACTIVE_W-1:0] cfg_data
);

    import llca_pkg::*;

    localparam int CW   = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam int CNTW = $clog2(MAX_CORES + 1);
    localparam int CMPW = (CNTW > ACTIVE_W) ? CNTW : ACTIVE_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    state_t                state_reg;
    logic [ACTIVE_W-1:0]   active_reg;
    logic [CNTW-1:0]       n_eff_reg;
    logic [WEIGHT_W-1:0]   weight_reg;
    logic                  last_reg;
    logic [CNTW-1:0]       rd_cnt_reg;
    logic                  q_vld_reg;
    logic [CNTW-1:0]       q_idx_reg;
    logic [LOAD_W-1:0]     best_load_reg;
    logic [CW-1:0]         best_idx_reg;
    logic [MAX_CORES-1:0]  core_vld_reg;
    logic                  out_valid_reg;
    logic [CORE_W-1:0]     out_core_reg;

    logic [LOAD_W-1:0]     mem [MAX_CORES];
    logic [LOAD_W-1:0]     mem_q;
    logic                  ent_vld_q;

    logic                  in_fire;
    logic                  rd_en;
    logic [CW-1:0]         rd_addr;
    logic [LOAD_W-1:0]     cur_load;
    logic                  upd_fire;
    logic [LOAD_W:0]       sum_full;
    logic [LOAD_W-1:0]     new_load;
    logic [CMPW-1:0]       act_ext;
    logic [CNTW-1:0]       n_eff_next;
    logic [CNTW-1:0]       last_idx;

    // Handshake outputs
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign assigned_core = out_core_reg;

    // Clamp the active core count to 1..MAX_CORES
    always_comb
    begin
        act_ext = CMPW'(active_reg);
        if (act_ext == '0)
            n_eff_next = CNTW'(1);
        else if (act_ext > CMPW'(MAX_CORES))
            n_eff_next = CNTW'(MAX_CORES);
        else
            n_eff_next = CNTW'(act_ext);
    end

    // Issue one load read per cycle during the scan
    assign rd_en    = (state_reg == ST_SCAN) && (rd_cnt_reg < n_eff_reg);
    assign rd_addr  = rd_cnt_reg[CW-1:0];
    assign cur_load = ent_vld_q ? mem_q : '0;
    assign last_idx = n_eff_reg - CNTW'(1);

    // Saturating add of the weight onto the chosen load
    assign sum_full = {1'b0, best_load_reg} + (LOAD_W+1)'(weight_reg);
    assign new_load = sum_full[LOAD_W] ? {LOAD_W{1'b1}} : sum_full[LOAD_W-1:0];
    assign upd_fire = (state_reg == ST_UPDATE) && (!out_valid_reg || out_ready);

    // Load memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (upd_fire)
        begin
            mem[best_idx_reg] <= new_load;
        end
        if (rd_en)
        begin
            mem_q     <= mem[rd_addr];
            ent_vld_q <= core_vld_reg[rd_addr];
        end
    end

    // Control, scan compare and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= ACTIVE_RESET;
            n_eff_reg     <= CNTW'(1);
            weight_reg    <= '0;
            last_reg      <= 1'b0;
            rd_cnt_reg    <= '0;
            q_vld_reg     <= 1'b0;
            q_idx_reg     <= '0;
            best_load_reg <= '0;
            best_idx_reg  <= '0;
            core_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_core_reg  <= '0;
        end
        else
        begin
            // Take configuration writes
            if (cfg_valid && cfg_ready)
            begin
                active_reg <= cfg_data;
            end

            // Drop the result once transferred, unless a new one replaces it
            if (out_valid_reg && out_ready && !upd_fire)
            begin
                out_valid_reg <= 1'b0;
            end

            // Track read data, which arrives in the cycle after issue
            q_vld_reg <= rd_en;
            q_idx_reg <= rd_cnt_reg;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        weight_reg <= job_weight;
                        last_reg   <= last_in_batch;
                        n_eff_reg  <= n_eff_next;
                        rd_cnt_reg <= '0;
                        state_reg  <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (rd_en)
                    begin
                        rd_cnt_reg <= rd_cnt_reg + CNTW'(1);
                    end
                    if (q_vld_reg)
                    begin
                        // Keep the strictly smaller load; first entry seeds it
                        if ((q_idx_reg == '0) || (cur_load < best_load_reg))
                        begin
                            best_load_reg <= cur_load;
                            best_idx_reg  <= q_idx_reg[CW-1:0];
                        end
                        if (q_idx_reg == last_idx)
                        begin
                            state_reg <= ST_UPDATE;
                        end
                    end
                end
                ST_UPDATE:
                begin
                    if (upd_fire)
                    begin
                        out_valid_reg <= 1'b1;
                        out_core_reg  <= CORE_W'(best_idx_reg);
                        // End of batch wipes every load at once
                        if (last_reg)
                            core_vld_reg <= '0;
                        else
                            core_vld_reg[best_idx_reg] <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // The chosen core always lies inside the active range
    a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        upd_fire |-> (CNTW'(best_idx_reg) < n_eff_reg))
        else $error("chosen core outside active range");

    // Read data only ever comes from an active core
    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        q_vld_reg |-> (q_idx_reg < n_eff_reg))
        else $error("scan read beyond active cores");

    // A batch end leaves every load cleared
    a_batch_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_fire && last_reg) |=> (core_vld_reg == '0))
        else $error("loads not cleared after batch end");

    // A result is produced only when the output register is free or draining
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> $stable(out_core_reg))
        else $error("result overwritten while stalled");

endmodule

// File: tb/tb_least_loaded_core_assigner_core.sv
// Self-checking testbench for the least-loaded core assigner core.
module tb_least_loaded_core_assigner_core;

    timeunit 1ns;
    timeprecision 1ps;

    import llca_pkg::*;

    localparam logic [LOAD_W-1:0]   LOAD_MAX      = {LOAD_W{1'b1}};
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX    = {WEIGHT_W{1'b1}};
    localparam int                  SETTLE_CYCLES = 72;
    localparam int                  QUIET_LIMIT   = 4000;
    localparam int                  RANDOM_JOBS   = 1500;

    typedef struct packed {
        logic                is_cfg;
        logic [ACTIVE_W-1:0] cfg_val;
        logic [WEIGHT_W-1:0] weight;
        logic                last;
        logic                typed;
        logic [CORE_W-1:0]   core;
    } step_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [WEIGHT_W-1:0] job_weight;
    logic                last_in_batch;
    logic                out_valid;
    logic                out_ready;
    logic [CORE_W-1:0]   assigned_core;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [ACTIVE_W-1:0] cfg_data;

    // Shadow of the scheduler state, advanced at every accepted transfer
    logic [LOAD_W-1:0]   shadow_load [MAX_CORES_DEF];
    logic [ACTIVE_W-1:0] shadow_active;
    logic [CORE_W-1:0]   pending_cores [$];
    step_t               directed [$];

    int  errors      = 0;
    int  jobs_sent   = 0;
    int  cores_seen  = 0;
    int  cfg_writes  = 0;
    int  sat_hits    = 0;
    int  top_core    = 0;
    int  ready_wait  = 0;
    int  quiet       = 0;
    bit  idle_on     = 1'b1;

    least_loaded_core_assigner_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .job_weight    (job_weight),
        .last_in_batch (last_in_batch),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .assigned_core (assigned_core),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Pick the least loaded active core and charge the job weight to it
    function automatic logic [CORE_W-1:0] pick_core(input logic [WEIGHT_W-1:0] w,
                                                    input logic last);
        int n;
        int best;
        if (shadow_active == '0)
            n = 1;
        else if (int'(shadow_active) > MAX_CORES_DEF)
            n = MAX_CORES_DEF;
        else
            n = int'(shadow_active);
        best = 0;
        for (int c = 1; c < n; c++)
        begin
            if (shadow_load[c] < shadow_load[best])
                best = c;
        end
        if (shadow_load[best] > LOAD_MAX - LOAD_W'(w))
        begin
            shadow_load[best] = LOAD_MAX;
            sat_hits++;
        end
        else
        begin
            shadow_load[best] = shadow_load[best] + LOAD_W'(w);
        end
        if (last)
        begin
            foreach (shadow_load[c])
                shadow_load[c] = '0;
        end
        return best[CORE_W-1:0];
    endfunction

    function automatic int draw_wait();
        return idle_on ? $urandom_range(17, 0) : 0;
    endfunction

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        case ($urandom_range(4, 0))
            0: return $urandom_range(15, 0);
            1: return $urandom_range(1023, 0);
            2: return WEIGHT_MAX;
            default: return $urandom;
        endcase
    endfunction

    function automatic step_t job_row(input logic [WEIGHT_W-1:0] w, input logic last,
                                      input logic typed, input logic [CORE_W-1:0] core);
        step_t s;
        s = '0;
        s.weight = w;
        s.last   = last;
        s.typed  = typed;
        s.core   = core;
        return s;
    endfunction

    function automatic step_t cfg_row(input logic [ACTIVE_W-1:0] v);
        step_t s;
        s = '0;
        s.is_cfg  = 1'b1;
        s.cfg_val = v;
        return s;
    endfunction

    // Present one job, hold it until the transfer, then queue the expected core
    task automatic send_job(input logic [WEIGHT_W-1:0] w, input logic last,
                            input logic typed, input logic [CORE_W-1:0] typed_core);
        int               gap;
        logic [CORE_W-1:0] want;
        gap = draw_wait();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      = 1'b1;
        job_weight    = w;
        last_in_batch = last;
        do @(posedge clk); while (!in_ready);
        want = pick_core(w, last);
        pending_cores.push_back(typed ? typed_core : want);
        jobs_sent++;
    endtask

    // Drop valid and hold until every queued core has come back
    task automatic wait_all_assigned();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_cores.size() != 0)
            @(negedge clk);
    endtask

    // Write the active core count once the block has gone quiet
    task automatic write_active(input logic [ACTIVE_W-1:0] v);
        wait_all_assigned();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = v;
        do @(posedge clk); while (!cfg_ready);
        shadow_active = v;
        cfg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Receiver: stall a drawn number of cycles before each result
    always @(negedge clk)
    begin
        if (ready_wait > 0)
        begin
            out_ready  = 1'b0;
            ready_wait = ready_wait - 1;
        end
        else
        begin
            out_ready = 1'b1;
        end
    end

    // Compare each result transfer with the oldest expected core
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_cores.size() == 0)
            begin
                $display("%0t: unexpected result, got assigned_core %0d", $time,
                         assigned_core);
                errors++;
            end
            else if (assigned_core !== pending_cores[0])
            begin
                $display("%0t: assigned_core mismatch, expected %0d, got %0d", $time,
                         pending_cores[0], assigned_core);
                errors++;
                void'(pending_cores.pop_front());
            end
            else
            begin
                void'(pending_cores.pop_front());
            end
            cores_seen++;
            if (int'(assigned_core) > top_core)
                top_core = int'(assigned_core);
            ready_wait = draw_wait();
        end
    end

    // Watchdog: end the run after too many cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet = quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, quiet);
            $display("least_loaded_core_assigner_core regression: fail");
            $finish;
        end
    end

    initial
    begin
        int                  blen;
        int                  phase_len;
        int                  phase_sent;
        int                  rand_sent;
        logic                last;
        logic [ACTIVE_W-1:0] v;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        job_weight    = '0;
        last_in_batch = 1'b0;
        out_ready     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        shadow_active = ACTIVE_RESET;
        foreach (shadow_load[c])
            shadow_load[c] = '0;
        ready_wait = draw_wait();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset count, ties, zero and oversized counts, batch clears
        directed.push_back(job_row(32'd0, 1'b0, 1'b1, 6'd0));
        directed.push_back(job_row(32'd5, 1'b0, 1'b1, 6'd0));
        directed.push_back(job_row(WEIGHT_MAX, 1'b0, 1'b1, 6'd1));
        directed.push_back(job_row(32'd1, 1'b1, 1'b1, 6'd2));
        directed.push_back(job_row(32'd7, 1'b0, 1'b1, 6'd0));
        directed.push_back(cfg_row(7'd0));
        directed.push_back(job_row(32'd3, 1'b0, 1'b1, 6'd0));
        directed.push_back(job_row(32'd9, 1'b1, 1'b1, 6'd0));
        directed.push_back(cfg_row(7'd1));
        directed.push_back(job_row(WEIGHT_MAX, 1'b0, 1'b1, 6'd0));
        directed.push_back(cfg_row(7'd127));
        directed.push_back(job_row(32'd100, 1'b0, 1'b1, 6'd1));
        directed.push_back(job_row(32'd50, 1'b0, 1'b1, 6'd2));
        directed.push_back(cfg_row(7'd65));
        directed.push_back(job_row(32'd1, 1'b1, 1'b1, 6'd3));
        directed.push_back(cfg_row(7'd2));
        directed.push_back(job_row(32'd10, 1'b0, 1'b1, 6'd0));
        directed.push_back(job_row(32'd4, 1'b0, 1'b0, 6'd0));
        directed.push_back(job_row(32'd3, 1'b0, 1'b0, 6'd0));
        directed.push_back(job_row(32'd3, 1'b0, 1'b0, 6'd0));
        directed.push_back(cfg_row(7'd63));
        directed.push_back(job_row(32'h8000_0000, 1'b0, 1'b0, 6'd0));
        directed.push_back(job_row(32'h7FFF_FFFF, 1'b1, 1'b0, 6'd0));
        directed.push_back(cfg_row(7'd64));
        directed.push_back(job_row(32'h5555_5555, 1'b0, 1'b1, 6'd0));
        directed.push_back(job_row(32'hAAAA_AAAA, 1'b1, 1'b1, 6'd1));

        foreach (directed[i])
        begin
            if (directed[i].is_cfg)
                write_active(directed[i].cfg_val);
            else
                send_job(directed[i].weight, directed[i].last, directed[i].typed,
                         directed[i].core);
        end

        // Random phases: new count per phase, mostly well-formed batches
        rand_sent = 0;
        while (rand_sent < RANDOM_JOBS)
        begin
            case ($urandom_range(5, 0))
                0: v = ACTIVE_W'($urandom_range(8, 0));
                1: v = 7'd64;
                2: v = ACTIVE_W'($urandom_range(127, 65));
                3: v = ACTIVE_W'($urandom_range(127, 0));
                default: v = ACTIVE_W'($urandom_range(12, 1));
            endcase
            write_active(v);
            idle_on    = ($urandom_range(3, 0) != 0);
            phase_len  = $urandom_range(140, 40);
            phase_sent = 0;
            while (phase_sent < phase_len)
            begin
                case ($urandom_range(2, 0))
                    0: blen = $urandom_range(4, 1);
                    1: blen = $urandom_range(20, 1);
                    default: blen = $urandom_range(150, 20);
                endcase
                for (int i = 0; i < blen; i++)
                begin
                    last = (i == blen - 1);
                    if ($urandom_range(19, 0) == 0)
                        last = ~last;
                    send_job(rand_weight(), last, 1'b0, '0);
                    if ($urandom_range(99, 0) == 0)
                        wait_all_assigned();
                end
                phase_sent += blen;
            end
            rand_sent += phase_sent;
        end

        // Drain and let the last write back settle
        wait_all_assigned();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Ran %0d jobs over %0d active core settings; %0d results checked.",
                 jobs_sent, cfg_writes, cores_seen);
        $display("Load clamps at the maximum: %0d; highest core index returned: %0d.",
                 sat_hits, top_core);
        if (errors == 0)
            $display("least_loaded_core_assigner_core regression: pass");
        else
            $display("least_loaded_core_assigner_core regression: fail");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/llca_pkg.sv
hw/rtl/least_loaded_core_assigner_core.sv
tb/tb_least_loaded_core_assigner_core.sv
